// ===== rtl/atip_pkg.sv =====
// Shared types and constants of the attenuation table interpolator.
`timescale 1ns / 1ps
package atip_pkg;

  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_LOOKUP_ONE = 2'd1,
    OP_LOOKUP_PCR = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  localparam logic [1:0] KIND_TOTAL    = 2'd0;
  localparam logic [1:0] KIND_PHOTO    = 2'd1;
  localparam logic [1:0] KIND_COMPTON  = 2'd2;
  localparam logic [1:0] KIND_RAYLEIGH = 2'd3;
  localparam int CURVE_KINDS = 4;

  localparam logic [1:0] CFG_MIN_ENERGY    = 2'd0;
  localparam logic [1:0] CFG_MAX_ENERGY    = 2'd1;
  localparam logic [1:0] CFG_ENERGY_STEP   = 2'd2;
  localparam logic [1:0] CFG_POINTS_IN_USE = 2'd3;

  localparam int QUEUE_DEPTH = 4;

  // Classified item as it waits between front and back.
  typedef struct packed {
    logic        is_write;
    logic        mode_pcr;
    logic        mat_bad;
    logic [2:0]  material;
    logic [1:0]  curve_kind;
    logic [7:0]  point_index;
    logic [31:0] entry_value;
    logic [15:0] diff;
    logic        low;
    logic        high;
  } item_t;

  // Lookup data that rides along with the table read.
  typedef struct packed {
    logic        mode_pcr;
    logic        mat_bad;
    logic        clamp;
    logic        odd_first;
    logic [1:0]  curve_kind;
    logic [15:0] frac;
  } rd_meta_t;

  typedef struct packed {
    logic mode_pcr;
    logic mat_bad;
    logic clamp;
  } res_meta_t;

  typedef struct packed {
    res_meta_t   meta;
    logic        neg;
    logic [31:0] y0;
  } lane_tag_t;

endpackage

// ===== rtl/atip_ifs.sv =====
// Input and output channel interfaces of the attenuation table interpolator.
`timescale 1ns / 1ps
interface atip_in_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [2:0]  material;
  logic [1:0]  curve_kind;
  logic [15:0] energy;
  logic [7:0]  point_index;
  logic [31:0] entry_value;

  modport source (output valid, opcode, material, curve_kind, energy, point_index,
                  entry_value, input ready);
  modport sink (input valid, opcode, material, curve_kind, energy, point_index,
                entry_value, output ready);
endinterface

interface atip_out_if ();
  logic        valid;
  logic        ready;
  logic [31:0] first_value;
  logic [31:0] second_value;
  logic [31:0] third_value;
  logic        was_clamped;

  modport source (output valid, first_value, second_value, third_value, was_clamped,
                  input ready);
  modport sink (input valid, first_value, second_value, third_value, was_clamped,
                output ready);
endinterface

// ===== rtl/atip_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module atip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/atip_front.sv =====
// Front end: takes input beats, classifies them and pushes them into the queue.
`timescale 1ns / 1ps
module atip_front import atip_pkg::*; #(
  parameter int MAX_MATERIALS = 8
) (
  atip_in_if.sink     in_ch,
  input  logic [15:0] min_energy,
  input  logic [15:0] max_energy,
  input  logic        q_full,
  output logic        push,
  output item_t       item
);
  assign in_ch.ready = !q_full;
  // Beats with the unused opcode are taken and dropped here.
  assign push = in_ch.valid && !q_full && (in_ch.opcode != OP_NONE);

  always_comb begin
    item.is_write    = (in_ch.opcode == OP_WRITE);
    item.mode_pcr    = (in_ch.opcode == OP_LOOKUP_PCR);
    item.mat_bad     = (int'(in_ch.material) >= MAX_MATERIALS);
    item.material    = in_ch.material;
    item.curve_kind  = in_ch.curve_kind;
    item.point_index = in_ch.point_index;
    item.entry_value = in_ch.entry_value;
    item.diff        = in_ch.energy - min_energy;
    item.low         = (in_ch.energy <= min_energy);
    item.high        = (in_ch.energy >= max_energy);
  end
endmodule

// ===== rtl/atip_queue.sv =====
// Short queue between front end and back end.
`timescale 1ns / 1ps
module atip_queue import atip_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t rdata
);
  localparam int CW = $clog2(QUEUE_DEPTH);

  item_t         mem [QUEUE_DEPTH];
  logic [CW-1:0] wptr;
  logic [CW-1:0] rptr;
  logic [CW:0]   count;

  assign full  = (count == (CW+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (CW+1)'(push) - (CW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end
endmodule

// ===== rtl/atip_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a tag alongside.
`timescale 1ns / 1ps
module atip_div #(
  parameter int NW = 17,
  parameter int Q  = 16,
  parameter int DW = 16,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [Q-1:0]  quot,
  output logic [DW-1:0] rem,
  output logic [TW-1:0] out_tag
);
  // The upper NW-Q bits of the dividend must be below the divisor.
  logic [DW-1:0] r  [Q+1];
  logic [Q-1:0]  qn [Q+1];
  logic [TW-1:0] tg [Q+1];
  logic          v  [Q+1];

  assign r[0]  = DW'(dividend[NW-1:Q]);
  assign qn[0] = dividend[Q-1:0];
  assign tg[0] = in_tag;
  assign v[0]  = in_valid;

  for (genvar s = 0; s < Q; s++) begin : g_stage
    logic [DW:0] t;
    logic        ge;
    assign t  = {r[s], qn[s][Q-1]};
    assign ge = (t >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[s+1]  <= ge ? DW'(t - {1'b0, divisor}) : t[DW-1:0];
        qn[s+1] <= {qn[s][Q-2:0], ge};
        tg[s+1] <= tg[s];
      end
    end
  end

  assign out_valid = v[Q];
  assign quot      = qn[Q];
  assign rem       = r[Q];
  assign out_tag   = tg[Q];
endmodule

// ===== rtl/atip_back.sv =====
// Back end: grid index division, banked table access, interpolation and output register.
`timescale 1ns / 1ps
module atip_back import atip_pkg::*; #(
  parameter int MAX_MATERIALS = 8,
  parameter int MAX_POINTS    = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  input  logic [15:0] step,
  input  logic [8:0]  points_in_use,
  atip_out_if.source  out_ch,
  output logic        en
);
  localparam int HALF  = (MAX_POINTS + 1) / 2;
  localparam int DEPTH = MAX_MATERIALS * HALF;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(MAX_POINTS);

  logic ovalid;

  assign en    = !ovalid || out_ch.ready;
  assign q_pop = en && q_valid;

  // Grid index and fraction.
  logic        iv;
  logic [15:0] iquot;
  logic [15:0] irem;
  item_t       it;

  atip_div #(.NW(17), .Q(16), .DW(16), .TW($bits(item_t))) u_idx_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (q_valid),
    .dividend ({1'b0, q_item.diff}),
    .divisor  (step),
    .in_tag   (q_item),
    .out_valid(iv),
    .quot     (iquot),
    .rem      (irem),
    .out_tag  (it)
  );

  // Resolve end cases and form the bank addresses.
  logic [15:0]   n16;
  logic [15:0]   nm1;
  logic          hi;
  logic          clamp;
  logic [PW-1:0] pt;
  logic [PW:0]   ptn;
  logic [AW-1:0] base;
  logic [AW-1:0] even_addr;
  logic [AW-1:0] odd_addr;
  logic [AW-1:0] waddr;
  logic          wok;

  always_comb begin
    if (points_in_use < 9'd2) begin
      n16 = 16'd2;
    end else if (16'(points_in_use) > 16'(MAX_POINTS)) begin
      n16 = 16'(MAX_POINTS);
    end else begin
      n16 = 16'(points_in_use);
    end
    nm1   = n16 - 16'd1;
    hi    = it.high || (iquot >= nm1);
    clamp = it.low || hi;
    if (it.low) begin
      pt = '0;
    end else if (hi) begin
      pt = PW'(nm1);
    end else begin
      pt = PW'(iquot);
    end
    ptn       = {1'b0, pt} + 1'b1;
    base      = AW'(it.material) * AW'(HALF);
    // Points idx and idx+1 always sit in different parity banks.
    odd_addr  = base + AW'(pt >> 1);
    even_addr = base + AW'(ptn >> 1);
    waddr     = base + AW'(it.point_index >> 1);
    wok       = iv && it.is_write && !it.mat_bad &&
                (13'(it.point_index) < 13'(MAX_POINTS));
  end

  logic [31:0] even_data [CURVE_KINDS];
  logic [31:0] odd_data  [CURVE_KINDS];

  for (genvar k = 0; k < CURVE_KINDS; k++) begin : g_kind
    logic we_even;
    logic we_odd;
    assign we_even = en && wok && (it.curve_kind == 2'(k)) && !it.point_index[0];
    assign we_odd  = en && wok && (it.curve_kind == 2'(k)) && it.point_index[0];

    atip_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_even (
      .clk  (clk),
      .we   (we_even),
      .waddr(waddr),
      .wdata(it.entry_value),
      .re   (en),
      .raddr(even_addr),
      .rdata(even_data[k])
    );

    atip_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_odd (
      .clk  (clk),
      .we   (we_odd),
      .waddr(waddr),
      .wdata(it.entry_value),
      .re   (en),
      .raddr(odd_addr),
      .rdata(odd_data[k])
    );
  end

  logic     mv;
  rd_meta_t md;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (en) begin
      mv <= iv && !it.is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md.mode_pcr   <= it.mode_pcr;
      md.mat_bad    <= it.mat_bad;
      md.clamp      <= clamp;
      md.odd_first  <= pt[0];
      md.curve_kind <= it.curve_kind;
      md.frac       <= clamp ? 16'd0 : irem;
    end
  end

  // Per lane: pick the curve, take |y1 - y0| and multiply by the fraction.
  logic        ev;
  logic [47:0] eprod [3];
  lane_tag_t   etag  [3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [1:0]  kind;
    logic [31:0] y0;
    logic [31:0] y1;
    logic        neg;
    logic [31:0] dy;

    always_comb begin
      if (l == 0) begin
        kind = md.mode_pcr ? KIND_PHOTO : md.curve_kind;
      end else if (l == 1) begin
        kind = KIND_COMPTON;
      end else begin
        kind = KIND_RAYLEIGH;
      end
      y0  = md.odd_first ? odd_data[kind] : even_data[kind];
      // An end entry needs no neighbor, which may lie outside the table.
      y1  = md.clamp ? y0 : (md.odd_first ? even_data[kind] : odd_data[kind]);
      neg = (y1 < y0);
      dy  = neg ? (y0 - y1) : (y1 - y0);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        eprod[l]          <= 48'(dy) * 48'(md.frac);
        etag[l].y0        <= y0;
        etag[l].neg       <= neg;
        etag[l].meta.mode_pcr <= md.mode_pcr;
        etag[l].meta.mat_bad  <= md.mat_bad;
        etag[l].meta.clamp    <= md.clamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= 1'b0;
    end else if (en) begin
      ev <= mv;
    end
  end

  // Divide the product by the step in each lane.
  logic        lv;
  logic [31:0] lq   [3];
  lane_tag_t   ltag [3];

  for (genvar l = 0; l < 3; l++) begin : g_ldiv
    if (l == 0) begin : g_main
      atip_div #(.NW(48), .Q(32), .DW(16), .TW($bits(lane_tag_t))) u_div (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .in_valid (ev),
        .dividend (eprod[l]),
        .divisor  (step),
        .in_tag   (etag[l]),
        .out_valid(lv),
        .quot     (lq[l]),
        .rem      (),
        .out_tag  (ltag[l])
      );
    end else begin : g_side
      atip_div #(.NW(48), .Q(32), .DW(16), .TW($bits(lane_tag_t))) u_div (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .in_valid (ev),
        .dividend (eprod[l]),
        .divisor  (step),
        .in_tag   (etag[l]),
        .out_valid(),
        .quot     (lq[l]),
        .rem      (),
        .out_tag  (ltag[l])
      );
    end
  end

  logic [31:0] res [3];

  for (genvar l = 0; l < 3; l++) begin : g_res
    assign res[l] = ltag[l].neg ? (ltag[l].y0 - lq[l]) : (ltag[l].y0 + lq[l]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (en) begin
      ovalid <= lv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.first_value  <= ltag[0].meta.mat_bad ? 32'd0 : res[0];
      out_ch.second_value <= (ltag[0].meta.mat_bad || !ltag[0].meta.mode_pcr) ?
                             32'd0 : res[1];
      out_ch.third_value  <= (ltag[0].meta.mat_bad || !ltag[0].meta.mode_pcr) ?
                             32'd0 : res[2];
      out_ch.was_clamped  <= !ltag[0].meta.mat_bad && ltag[0].meta.clamp;
    end
  end

  assign out_ch.valid = ovalid;
endmodule

// ===== rtl/attenuation_table_interp.sv =====
// Top level of the attenuation table interpolator.
`timescale 1ns / 1ps
// Holds four attenuation curves per material on a uniform energy grid and
// answers lookups by linear interpolation between neighboring grid points.
// Write beats load one entry and give no result; lookup beats give one result
// each, in order. The block takes one beat per cycle and delivers one result
// per cycle when the output side keeps up; from acceptance to result, a lookup
// passes through the 16-stage grid index divider and the 32-stage
// interpolation dividers, with a 4-entry queue behind the input.
// The table sits in eight RAM banks (curve by point parity), each
// MAX_MATERIALS * ceil(MAX_POINTS/2) words, and is not cleared by reset:
// read only entries that were written.
module attenuation_table_interp import atip_pkg::*; #(
  parameter int MAX_MATERIALS = 8,
  parameter int MAX_POINTS    = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  atip_in_if.sink     in_ch,
  atip_out_if.source  out_ch
);
  logic [15:0] min_energy;
  logic [15:0] max_energy;
  logic [15:0] energy_step;
  logic [8:0]  points_in_use;
  logic [15:0] step_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_energy    <= 16'd0;
      max_energy    <= 16'd9600;
      energy_step   <= 16'd64;
      points_in_use <= 9'd150;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_ENERGY:    min_energy    <= cfg_data;
        CFG_MAX_ENERGY:    max_energy    <= cfg_data;
        CFG_ENERGY_STEP:   energy_step   <= cfg_data;
        CFG_POINTS_IN_USE: points_in_use <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // A zero step behaves as a step of one.
  assign step_eff = (energy_step == 16'd0) ? 16'd1 : energy_step;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  item_t q_in;
  item_t q_out;
  logic  back_en;

  atip_front #(.MAX_MATERIALS(MAX_MATERIALS)) u_front (
    .in_ch     (in_ch),
    .min_energy(min_energy),
    .max_energy(max_energy),
    .q_full    (q_full),
    .push      (q_push),
    .item      (q_in)
  );

  atip_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_in),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .rdata(q_out)
  );

  atip_back #(.MAX_MATERIALS(MAX_MATERIALS), .MAX_POINTS(MAX_POINTS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_out),
    .q_pop        (q_pop),
    .step         (step_eff),
    .points_in_use(points_in_use),
    .out_ch       (out_ch),
    .en           (back_en)
  );

  // The back end only stalls behind a result that is not being taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !back_en |-> (out_ch.valid && !out_ch.ready))
    else $error("back end stalled without output backpressure");

  // The queue is only popped when it holds a beat.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // Nothing leaves the block in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $fell(rst) |-> !out_ch.valid)
    else $error("result shown right after reset");
endmodule
